/* rtl/tpc_pkg.sv */
// Shared types and flag codes for the passive TCP connection state machine.
package tpc_pkg;

  // TCP flag bits
  localparam logic [7:0] FLAG_FIN = 8'h01;
  localparam logic [7:0] FLAG_SYN = 8'h02;
  localparam logic [7:0] FLAG_RST = 8'h04;
  localparam logic [7:0] FLAG_PSH = 8'h08;
  localparam logic [7:0] FLAG_ACK = 8'h10;
  localparam logic [7:0] FLAG_URG = 8'h20;

  // Owed-segment marks
  localparam int unsigned MARK_SYNACK = 0;
  localparam int unsigned MARK_FIN    = 1;
  localparam int unsigned MARK_ACK    = 2;

  localparam logic [15:0] OWN_WINDOW  = 16'hFFFF;
  localparam logic [15:0] MSS_RESET   = 16'd536;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_INITIAL_SEQ = 2'd0;
  localparam logic [1:0] REG_LOCAL_IP    = 2'd1;
  localparam logic [1:0] REG_LOCAL_PORT  = 2'd2;
  localparam logic [1:0] REG_DEFAULT_MSS = 2'd3;

  typedef struct packed {
    logic        func;
    logic        checksum_ok;
    logic [7:0]  seg_flags;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic [31:0] seq_in;
    logic [31:0] ack_in;
    logic [15:0] window_in;
    logic [15:0] data_len;
    logic [15:0] mss_option;
    logic [3:0]  wscale_option;
    logic [31:0] ts_value;
  } item_t;

  typedef struct packed {
    logic [7:0]  out_flags;
    logic [31:0] out_seq;
    logic [31:0] out_ack;
    logic [15:0] out_window;
    logic [16:0] send_offset;
    logic [16:0] send_len;
    logic [31:0] echo_timestamp;
    logic [31:0] remote_ip;
    logic [15:0] remote_port;
  } result_t;

  typedef struct packed {
    logic [31:0] initial_seq;
    logic [15:0] default_mss;
  } cfg_t;

endpackage

/* rtl/tcp_passive_connection_fsm.sv */
// Passive TCP endpoint: input register, connection core, result register.
// A beat's result passes the input register, then the result register.
// Throughput: one input beat per cycle; input stalls only while the output skid
// stage holds a second result that the consumer has not taken.
// Reset (rst, synchronous): state listen, all counters and marks cleared,
// default MSS 536, no beats held on either channel.
module tcp_passive_connection_fsm #(
  parameter int unsigned SEND_BUFFER_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic        checksum_ok,
  input  logic [7:0]  seg_flags,
  input  logic [31:0] peer_ip,
  input  logic [15:0] peer_port,
  input  logic [31:0] seq_in,
  input  logic [31:0] ack_in,
  input  logic [15:0] window_in,
  input  logic [15:0] data_len,
  input  logic [15:0] mss_option,
  input  logic [3:0]  wscale_option,
  input  logic [31:0] ts_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_flags,
  output logic [31:0] out_seq,
  output logic [31:0] out_ack,
  output logic [15:0] out_window,
  output logic [16:0] send_offset,
  output logic [16:0] send_len,
  output logic [31:0] echo_timestamp,
  output logic [31:0] remote_ip,
  output logic [15:0] remote_port,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tpc_pkg::*;

  item_t   item;
  logic    item_valid;
  cfg_t    cfg;
  result_t res, res_q;
  logic    emit, space, fire;

  assign fire     = item_valid && space;
  assign in_ready = !item_valid || space;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (fire) begin
      item_valid <= 1'b0;
    end
  end

  // hold the accepted beat until the core consumes it
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.func          <= func;
      item.checksum_ok   <= checksum_ok;
      item.seg_flags     <= seg_flags;
      item.peer_ip       <= peer_ip;
      item.peer_port     <= peer_port;
      item.seq_in        <= seq_in;
      item.ack_in        <= ack_in;
      item.window_in     <= window_in;
      item.data_len      <= data_len;
      item.mss_option    <= mss_option;
      item.wscale_option <= wscale_option;
      item.ts_value      <= ts_value;
    end
  end

  tpc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tpc_core #(
    .SEND_BUFFER_BYTES (SEND_BUFFER_BYTES)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .cfg    (cfg),
    .emit   (emit),
    .result (res)
  );

  tpc_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (fire && emit),
    .din       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (res_q)
  );

  assign out_flags      = res_q.out_flags;
  assign out_seq        = res_q.out_seq;
  assign out_ack        = res_q.out_ack;
  assign out_window     = res_q.out_window;
  assign send_offset    = res_q.send_offset;
  assign send_len       = res_q.send_len;
  assign echo_timestamp = res_q.echo_timestamp;
  assign remote_ip      = res_q.remote_ip;
  assign remote_port    = res_q.remote_port;

endmodule

/* rtl/tpc_cfg.sv */
// APB register file for the connection's configuration.
module tpc_cfg (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  output tpc_pkg::cfg_t cfg
);
  import tpc_pkg::*;

  logic [31:0] initial_seq;
  logic [31:0] local_ip;
  logic [15:0] local_port;
  logic [15:0] default_mss;
  logic        wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_seq <= '0;
      local_ip    <= '0;
      local_port  <= '0;
      default_mss <= MSS_RESET;
    end else if (wr) begin
      case (paddr[3:2])
        REG_INITIAL_SEQ: initial_seq <= pwdata;
        REG_LOCAL_IP:    local_ip    <= pwdata;
        REG_LOCAL_PORT:  local_port  <= pwdata[15:0];
        REG_DEFAULT_MSS: default_mss <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_INITIAL_SEQ: prdata = initial_seq;
      REG_LOCAL_IP:    prdata = local_ip;
      REG_LOCAL_PORT:  prdata = {16'd0, local_port};
      REG_DEFAULT_MSS: prdata = {16'd0, default_mss};
      default:         prdata = '0;
    endcase
  end

  assign cfg.initial_seq = initial_seq;
  assign cfg.default_mss = default_mss;

endmodule

/* rtl/tpc_core.sv */
// Connection state, counters and next-segment selection for one beat.
module tpc_core #(
  parameter int unsigned SEND_BUFFER_BYTES = 65536
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  tpc_pkg::item_t   item,
  input  tpc_pkg::cfg_t    cfg,
  output logic             emit,
  output tpc_pkg::result_t result
);
  import tpc_pkg::*;

  localparam int unsigned QW = $clog2(SEND_BUFFER_BYTES + 1);
  localparam logic [QW-1:0] BUF_BYTES = QW'(SEND_BUFFER_BYTES);

  typedef enum logic [2:0] {
    LISTEN, SYN_RCVD, ESTABLISHED, TEARING, CLOSED
  } conn_t;

  conn_t         conn_state, conn_state_next;
  logic [31:0]   peer_address, peer_address_next;
  logic [15:0]   peer_port_reg, peer_port_reg_next;
  logic [31:0]   send_seq, send_seq_next;
  logic [31:0]   send_una, send_una_next;
  logic [31:0]   recv_seq, recv_seq_next;
  logic [15:0]   peer_window, peer_window_next;
  logic [15:0]   peer_mss, peer_mss_next;
  logic [3:0]    peer_shift, peer_shift_next;
  logic [31:0]   echo_value, echo_value_next;
  logic [QW-1:0] queued, queued_next;
  logic [2:0]    marks, marks_next;

  logic [31:0]   adv, in_flight, win_bytes, unsent_w, size_a, room_w, dlen_w;
  logic [QW-1:0] room, unsent;
  logic [15:0]   mss_eff, seg_len;
  logic          take, has_data, ack_in_range, ack_is_next;
  logic [7:0]    fl;

  assign fl           = item.seg_flags;
  assign adv          = item.ack_in - send_una;
  assign in_flight    = send_seq - send_una;
  assign take         = (adv != 32'd0) && (adv <= 32'(queued));
  assign ack_in_range = adv <= in_flight;
  assign ack_is_next  = item.ack_in == send_seq + 32'd1;
  // unsent bytes are the same before and after the ack is taken
  assign has_data     = in_flight < 32'(queued);
  assign unsent       = queued - in_flight[QW-1:0];
  assign unsent_w     = 32'(unsent);
  assign win_bytes    = 32'(item.window_in) << peer_shift;
  assign mss_eff      = (peer_mss != 16'd0) ? peer_mss : cfg.default_mss;
  assign size_a       = (unsent_w < win_bytes) ? unsent_w : win_bytes;
  assign seg_len      = (size_a < 32'(mss_eff)) ? size_a[15:0] : mss_eff;
  assign room         = BUF_BYTES - queued;
  assign room_w       = 32'(room);
  assign dlen_w       = 32'(item.data_len);

  always_comb begin
    conn_state_next    = conn_state;
    peer_address_next  = peer_address;
    peer_port_reg_next = peer_port_reg;
    send_seq_next      = send_seq;
    send_una_next      = send_una;
    recv_seq_next      = recv_seq;
    peer_window_next   = peer_window;
    peer_mss_next      = peer_mss;
    peer_shift_next    = peer_shift;
    echo_value_next    = echo_value;
    queued_next        = queued;
    marks_next         = marks;
    emit               = 1'b0;
    result             = '0;
    result.out_window  = OWN_WINDOW;

    if (item.func) begin
      // append, saturating at the buffer size
      queued_next = queued + ((dlen_w < room_w) ? QW'(item.data_len) : room);
    end else if (item.checksum_ok) begin
      case (conn_state)
        LISTEN: begin
          if ((fl & FLAG_RST) != 8'd0) begin
            conn_state_next = CLOSED;
          end else if (((fl & (FLAG_FIN | FLAG_PSH | FLAG_ACK | FLAG_URG)) == 8'd0) &&
                       ((fl & FLAG_SYN) != 8'd0)) begin
            peer_address_next  = item.peer_ip;
            peer_port_reg_next = item.peer_port;
            if (item.mss_option != 16'd0) peer_mss_next = item.mss_option;
            if (item.wscale_option != 4'hF) peer_shift_next = item.wscale_option;
            echo_value_next    = item.ts_value;
            send_seq_next      = cfg.initial_seq;
            send_una_next      = cfg.initial_seq;
            recv_seq_next      = item.seq_in + 32'd1;
            peer_window_next   = item.window_in;
            conn_state_next    = SYN_RCVD;
            emit                  = 1'b1;
            result.out_flags      = FLAG_SYN | FLAG_ACK;
            result.out_seq        = cfg.initial_seq;
            result.out_ack        = item.seq_in + 32'd1;
            result.echo_timestamp = item.ts_value;
            result.remote_ip      = item.peer_ip;
            result.remote_port    = item.peer_port;
          end
        end
        SYN_RCVD: begin
          if ((fl & FLAG_RST) != 8'd0) begin
            conn_state_next = CLOSED;
          end else if (((fl & (FLAG_FIN | FLAG_PSH | FLAG_SYN | FLAG_URG)) == 8'd0) &&
                       ((fl & FLAG_ACK) != 8'd0) && ack_is_next) begin
            send_seq_next    = send_seq + 32'd1;
            send_una_next    = send_una + 32'd1;
            echo_value_next  = item.ts_value;
            peer_window_next = item.window_in;
            conn_state_next  = ESTABLISHED;
          end
        end
        ESTABLISHED: begin
          if (((fl & FLAG_ACK) != 8'd0) && ack_in_range) begin
            if (take) begin
              send_una_next = item.ack_in;
              queued_next   = queued - adv[QW-1:0];
            end
            echo_value_next = item.ts_value;
            if ((fl & FLAG_RST) != 8'd0) begin
              conn_state_next = CLOSED;
            end else begin
              peer_window_next = item.window_in;
              recv_seq_next    = recv_seq + dlen_w + 32'((fl & FLAG_FIN) != 8'd0);
              if (item.data_len != 16'd0) marks_next[MARK_ACK] = 1'b1;
              if ((fl & FLAG_FIN) != 8'd0) begin
                marks_next[MARK_FIN] = 1'b1;
                conn_state_next      = TEARING;
              end
              result.out_ack        = recv_seq_next;
              result.echo_timestamp = item.ts_value;
              result.remote_ip      = peer_address;
              result.remote_port    = peer_port_reg;
              result.out_seq        = send_seq;
              // pick the owed segment in priority order
              if (marks_next[MARK_SYNACK]) begin
                marks_next[MARK_SYNACK] = 1'b0;
                emit             = 1'b1;
                result.out_flags = FLAG_SYN | FLAG_ACK;
              end else if (has_data) begin
                marks_next[MARK_ACK] = 1'b0;
                send_seq_next        = send_seq + 32'(seg_len);
                emit                 = 1'b1;
                result.out_flags     = FLAG_ACK | FLAG_PSH;
                result.send_offset   = 17'(send_seq - send_una_next);
                result.send_len      = 17'(seg_len);
              end else if (marks_next[MARK_FIN]) begin
                marks_next[MARK_FIN] = 1'b0;
                marks_next[MARK_ACK] = 1'b0;
                emit                 = 1'b1;
                result.out_flags     = FLAG_ACK | FLAG_FIN;
              end else if (marks_next[MARK_ACK]) begin
                marks_next[MARK_ACK] = 1'b0;
                emit                 = 1'b1;
                result.out_flags     = FLAG_ACK;
              end
            end
          end
        end
        TEARING: begin
          if (ack_is_next) begin
            if (take) begin
              send_una_next = item.ack_in;
              queued_next   = queued - adv[QW-1:0];
            end
            conn_state_next = CLOSED;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      conn_state    <= LISTEN;
      peer_address  <= '0;
      peer_port_reg <= '0;
      send_seq      <= '0;
      send_una      <= '0;
      recv_seq      <= '0;
      peer_window   <= '0;
      peer_mss      <= '0;
      peer_shift    <= '0;
      echo_value    <= '0;
      queued        <= '0;
      marks         <= '0;
    end else if (fire) begin
      conn_state    <= conn_state_next;
      peer_address  <= peer_address_next;
      peer_port_reg <= peer_port_reg_next;
      send_seq      <= send_seq_next;
      send_una      <= send_una_next;
      recv_seq      <= recv_seq_next;
      peer_window   <= peer_window_next;
      peer_mss      <= peer_mss_next;
      peer_shift    <= peer_shift_next;
      echo_value    <= echo_value_next;
      queued        <= queued_next;
      marks         <= marks_next;
    end
  end

endmodule

/* rtl/tpc_out_reg.sv */
// Result register with a skid stage on the output channel.
module tpc_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tpc_pkg::result_t din,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output tpc_pkg::result_t dout
);
  import tpc_pkg::*;

  result_t skid;
  logic    skid_valid;
  logic    pop;

  assign space = !skid_valid;
  assign pop   = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // no push can arrive while the skid is full
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) dout <= skid;
    end else if (push) begin
      if (out_valid && !pop) skid <= din;
      else                   dout <= din;
    end
  end

endmodule
